FILE: rtl/core/vfpe_pkg.sv
// ----------------------------------------------------------------------------
// vfpe_pkg
// Widths, register indexes, plane codes and reset values for the frustum
// plane extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package vfpe_pkg;

  localparam int ROW_W   = 16;  // 4.12 rotation component
  localparam int POS_W   = 32;  // 20.12 position component
  localparam int CFG_W   = 10;  // half_width, half_height, focal_length
  localparam int FAR_W   = 16;
  localparam int OFS_W   = 40;
  localparam int PLANE_W = 3;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;
  localparam int FRAC_W  = 12;

  // normal stage: 16b signed times 11b signed, then one add
  localparam int NPROD_W = ROW_W + CFG_W + 1;
  localparam int NSUM_W  = NPROD_W + 1;
  // offset stage: 16b times 32b, then a sum of three
  localparam int DPROD_W = ROW_W + POS_W;
  localparam int DSUM_W  = DPROD_W + 2;
  localparam int DOT_W   = DSUM_W - FRAC_W;

  localparam logic [CIDX_W-1:0] REG_HALF_WIDTH   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HALF_HEIGHT  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FOCAL_LENGTH = 2'd2;
  localparam logic [CIDX_W-1:0] REG_FAR_DISTANCE = 2'd3;

  localparam logic [PLANE_W-1:0] PLANE_NEAR      = 3'd0;
  localparam logic [PLANE_W-1:0] PLANE_FAR       = 3'd1;
  localparam logic [PLANE_W-1:0] PLANE_RIGHT_POS = 3'd2;
  localparam logic [PLANE_W-1:0] PLANE_RIGHT_NEG = 3'd3;
  localparam logic [PLANE_W-1:0] PLANE_UP_POS    = 3'd4;
  localparam logic [PLANE_W-1:0] PLANE_UP_NEG    = 3'd5;

  localparam logic [CFG_W-1:0] RST_HALF_WIDTH   = 10'd160;
  localparam logic [CFG_W-1:0] RST_HALF_HEIGHT  = 10'd120;
  localparam logic [CFG_W-1:0] RST_FOCAL_LENGTH = 10'd120;
  localparam logic [FAR_W-1:0] RST_FAR_DISTANCE = 16'd2000;

  typedef logic signed [ROW_W-1:0] row_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

FILE: rtl/core/view_frustum_plane_extract.sv
// ----------------------------------------------------------------------------
// view_frustum_plane_extract
// Turns one camera pose into six clipping planes, one plane word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one pose word, rotation rows right, up,
// forward in 4.12 and position in 20.12. Output channel (out_valid /
// out_stall): six plane words per pose, near, far, +right, -right, +up, -up,
// last_plane set on the sixth.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
// only while no pose is in flight. Index 0 half_width, 1 half_height,
// 2 focal_length, 3 far_distance.
// Throughput: one plane word per cycle while the output is not stalled; the
// pose holding register is reused for each of its six planes, and the next
// pose is taken in the cycle its last plane issues.
// Five register stages: normal products, normal sum, offset products,
// offset sum, output register.
// Reset clears all valid bits and loads the register defaults.
// When out_stall is high with out_valid set the whole pipeline holds; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module view_frustum_plane_extract (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  vfpe_pkg::row_t                 right_x,
  input  wire  vfpe_pkg::row_t                 right_y,
  input  wire  vfpe_pkg::row_t                 right_z,
  input  wire  vfpe_pkg::row_t                 up_x,
  input  wire  vfpe_pkg::row_t                 up_y,
  input  wire  vfpe_pkg::row_t                 up_z,
  input  wire  vfpe_pkg::row_t                 forward_x,
  input  wire  vfpe_pkg::row_t                 forward_y,
  input  wire  vfpe_pkg::row_t                 forward_z,
  input  wire  vfpe_pkg::pos_t                 pos_x,
  input  wire  vfpe_pkg::pos_t                 pos_y,
  input  wire  vfpe_pkg::pos_t                 pos_z,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [vfpe_pkg::PLANE_W-1:0]         plane_index,
  output vfpe_pkg::row_t                       normal_x,
  output vfpe_pkg::row_t                       normal_y,
  output vfpe_pkg::row_t                       normal_z,
  output logic signed [vfpe_pkg::OFS_W-1:0]    plane_offset,
  output logic                                 last_plane,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [vfpe_pkg::CIDX_W-1:0]          cfg_index,
  input  wire  [vfpe_pkg::CDATA_W-1:0]         cfg_data
);
  import vfpe_pkg::*;

  // config registers
  logic [CFG_W-1:0] half_width, half_height, focal_length;
  logic [FAR_W-1:0] far_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= RST_HALF_WIDTH;
      half_height  <= RST_HALF_HEIGHT;
      focal_length <= RST_FOCAL_LENGTH;
      far_distance <= RST_FAR_DISTANCE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_WIDTH:   half_width   <= cfg_data[CFG_W-1:0];
        REG_HALF_HEIGHT:  half_height  <= cfg_data[CFG_W-1:0];
        REG_FOCAL_LENGTH: focal_length <= cfg_data[CFG_W-1:0];
        REG_FAR_DISTANCE: far_distance <= cfg_data[FAR_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless the output word is held
  logic adv;
  assign adv = !out_valid || !out_stall;

  // pose holding register and plane sequencer
  row_t             pose_rgt [3];
  row_t             pose_up  [3];
  row_t             pose_fwd [3];
  pos_t             pose_pos [3];
  logic             busy;
  logic [PLANE_W-1:0] cnt;
  logic             issue_last;
  logic             in_take;

  assign issue_last = busy && (cnt == PLANE_UP_NEG) && adv;
  assign in_stall   = busy && !issue_last;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= PLANE_NEAR;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
        cnt  <= PLANE_NEAR;
      end else if (issue_last) begin
        busy <= 1'b0;
      end else if (busy && adv) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pose_rgt <= '{right_x, right_y, right_z};
      pose_up  <= '{up_x, up_y, up_z};
      pose_fwd <= '{forward_x, forward_y, forward_z};
      pose_pos <= '{pos_x, pos_y, pos_z};
    end
  end

  // stage 1: row*focal and forward*extent
  logic                      s1_valid;
  logic [PLANE_W-1:0]        s1_plane;
  logic signed [NPROD_W-1:0] s1_prow [3];
  logic signed [NPROD_W-1:0] s1_pfwd [3];
  row_t                      s1_fwd  [3];
  pos_t                      s1_pos  [3];

  logic signed [NPROD_W-1:0] prow_c [3];
  logic signed [NPROD_W-1:0] pfwd_c [3];
  logic [CFG_W-1:0]          ext_c;
  logic                      use_up_c;

  always_comb begin
    use_up_c = (cnt == PLANE_UP_POS) || (cnt == PLANE_UP_NEG);
    ext_c    = use_up_c ? half_height : half_width;
    for (int i = 0; i < 3; i++) begin
      prow_c[i] = (use_up_c ? pose_up[i] : pose_rgt[i]) *
                  $signed({1'b0, focal_length});
      pfwd_c[i] = pose_fwd[i] * $signed({1'b0, ext_c});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_plane <= cnt;
      s1_prow  <= prow_c;
      s1_pfwd  <= pfwd_c;
      s1_fwd   <= pose_fwd;
      s1_pos   <= pose_pos;
    end
  end

  // stage 2: normal
  logic               s2_valid;
  logic [PLANE_W-1:0] s2_plane;
  row_t               s2_nrm  [3];
  row_t               s2_dnrm [3];
  pos_t               s2_pos  [3];

  logic signed [NSUM_W-1:0] nsum_c [3];
  row_t                     nrm_c  [3];
  row_t                     dnrm_c [3];
  logic                     sub_c;

  always_comb begin
    sub_c = s1_plane[0];  // odd side planes take the negated row
    for (int i = 0; i < 3; i++) begin
      nsum_c[i] = sub_c ? NSUM_W'(s1_pfwd[i]) - NSUM_W'(s1_prow[i])
                        : NSUM_W'(s1_pfwd[i]) + NSUM_W'(s1_prow[i]);
      case (s1_plane)
        PLANE_NEAR: nrm_c[i] = s1_fwd[i];
        PLANE_FAR: begin
          // negating the most negative value saturates
          if (s1_fwd[i] == row_t'({1'b1, {(ROW_W-1){1'b0}}}))
            nrm_c[i] = row_t'({1'b0, {(ROW_W-1){1'b1}}});
          else
            nrm_c[i] = -s1_fwd[i];
        end
        default: nrm_c[i] = nsum_c[i][FRAC_W +: ROW_W];
      endcase
      // far offset is built from the forward row dot, not the negated normal
      dnrm_c[i] = (s1_plane == PLANE_FAR) ? s1_fwd[i] : nrm_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_plane <= s1_plane;
      s2_nrm   <= nrm_c;
      s2_dnrm  <= dnrm_c;
      s2_pos   <= s1_pos;
    end
  end

  // stage 3: normal * position
  logic                      s3_valid;
  logic [PLANE_W-1:0]        s3_plane;
  row_t                      s3_nrm  [3];
  logic signed [DPROD_W-1:0] s3_prod [3];
  logic signed [DPROD_W-1:0] dprod_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod_c[i] = s2_dnrm[i] * s2_pos[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_plane <= s2_plane;
      s3_nrm   <= s2_nrm;
      s3_prod  <= dprod_c;
    end
  end

  // stage 4: dot sum, floor shift
  logic                    s4_valid;
  logic [PLANE_W-1:0]      s4_plane;
  row_t                    s4_nrm [3];
  logic signed [DOT_W-1:0] s4_dot;
  logic signed [DSUM_W-1:0] dsum_c;

  assign dsum_c = DSUM_W'(s3_prod[0]) + DSUM_W'(s3_prod[1]) + DSUM_W'(s3_prod[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_plane <= s3_plane;
      s4_nrm   <= s3_nrm;
      s4_dot   <= dsum_c[DSUM_W-1:FRAC_W];
    end
  end

  // stage 5: offset, output register
  logic signed [OFS_W-1:0] dot_ext_c;
  logic signed [OFS_W-1:0] ofs_c;

  assign dot_ext_c = OFS_W'(s4_dot);

  always_comb begin
    if (s4_plane == PLANE_FAR)
      ofs_c = dot_ext_c + $signed(OFS_W'({far_distance, {FRAC_W{1'b0}}}));
    else
      ofs_c = -dot_ext_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plane_index  <= s4_plane;
      normal_x     <= s4_nrm[0];
      normal_y     <= s4_nrm[1];
      normal_z     <= s4_nrm[2];
      plane_offset <= ofs_c;
      last_plane   <= (s4_plane == PLANE_UP_NEG);
    end
  end

endmodule

`default_nettype wire

FILE: sim/frustum_plane_sb_pkg.sv
// ----------------------------------------------------------------------------
// frustum_plane_sb_pkg
// Pose and plane word types plus a scoreboard that predicts the six clipping
// planes of each accepted pose and checks the plane words that come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package frustum_plane_sb_pkg;

  import vfpe_pkg::*;

  typedef struct packed {
    row_t right_x;
    row_t right_y;
    row_t right_z;
    row_t up_x;
    row_t up_y;
    row_t up_z;
    row_t forward_x;
    row_t forward_y;
    row_t forward_z;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
  } pose_t;

  typedef struct packed {
    logic [PLANE_W-1:0]      index;
    row_t                    normal_x;
    row_t                    normal_y;
    row_t                    normal_z;
    logic signed [OFS_W-1:0] offset;
    logic                    last;
  } plane_word_t;

  class plane_scoreboard;
    logic [CFG_W-1:0] half_width;
    logic [CFG_W-1:0] half_height;
    logic [CFG_W-1:0] focal_length;
    logic [FAR_W-1:0] far_distance;
    plane_word_t      expected_planes[$];
    int               errors;

    function new();
      half_width   = RST_HALF_WIDTH;
      half_height  = RST_HALF_HEIGHT;
      focal_length = RST_FOCAL_LENGTH;
      far_distance = RST_FAR_DISTANCE;
      errors       = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] index, logic [CDATA_W-1:0] data);
      case (index)
        REG_HALF_WIDTH:   half_width   = data[CFG_W-1:0];
        REG_HALF_HEIGHT:  half_height  = data[CFG_W-1:0];
        REG_FOCAL_LENGTH: focal_length = data[CFG_W-1:0];
        REG_FAR_DISTANCE: far_distance = data[FAR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_planes.size();
    endfunction

    function void add_plane(int k, longint nx, longint ny, longint nz, longint d);
      plane_word_t w;
      w.index    = PLANE_W'(k);
      w.normal_x = ROW_W'(nx);
      w.normal_y = ROW_W'(ny);
      w.normal_z = ROW_W'(nz);
      w.offset   = OFS_W'(d);
      w.last     = (k == PLANE_UP_NEG);
      expected_planes.push_back(w);
    endfunction

    // Six planes per pose; all math in 64 bits, >>> floors on signed values.
    function void note_pose(pose_t p);
      longint rgt[3], upr[3], fwd[3], pos[3], nrm[3];
      longint fd, ext, foc, r;
      bit     use_right, neg;
      rgt[0] = p.right_x;   rgt[1] = p.right_y;   rgt[2] = p.right_z;
      upr[0] = p.up_x;      upr[1] = p.up_y;      upr[2] = p.up_z;
      fwd[0] = p.forward_x; fwd[1] = p.forward_y; fwd[2] = p.forward_z;
      pos[0] = p.pos_x;     pos[1] = p.pos_y;     pos[2] = p.pos_z;
      foc = longint'(focal_length);

      fd = (fwd[0] * pos[0] + fwd[1] * pos[1] + fwd[2] * pos[2]) >>> FRAC_W;
      add_plane(PLANE_NEAR, fwd[0], fwd[1], fwd[2], -fd);

      // negating the most negative component clips to the top of the range
      for (int i = 0; i < 3; i++)
        nrm[i] = (-fwd[i] > 32767) ? 32767 : -fwd[i];
      add_plane(PLANE_FAR, nrm[0], nrm[1], nrm[2], fd + longint'(far_distance) * 4096);

      for (int k = PLANE_RIGHT_POS; k <= PLANE_UP_NEG; k++) begin
        use_right = (k == PLANE_RIGHT_POS) || (k == PLANE_RIGHT_NEG);
        neg       = (k == PLANE_RIGHT_NEG) || (k == PLANE_UP_NEG);
        ext       = use_right ? longint'(half_width) : longint'(half_height);
        for (int i = 0; i < 3; i++) begin
          r = use_right ? rgt[i] : upr[i];
          if (neg) r = -r;
          nrm[i] = (r * foc + fwd[i] * ext) >>> FRAC_W;
        end
        add_plane(k, nrm[0], nrm[1], nrm[2],
                  -((nrm[0] * pos[0] + nrm[1] * pos[1] + nrm[2] * pos[2]) >>> FRAC_W));
      end
    endfunction

    function void check_plane(plane_word_t got);
      plane_word_t want;
      if (expected_planes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected plane word index %0d n (%0d,%0d,%0d) d %0d last %0b",
                   got.index, got.normal_x, got.normal_y, got.normal_z, got.offset,
                   got.last);
        return;
      end
      want = expected_planes.pop_front();
      if (got.index !== want.index || got.normal_x !== want.normal_x ||
          got.normal_y !== want.normal_y || got.normal_z !== want.normal_z ||
          got.offset !== want.offset || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: mismatch expected index %0d n (%0d,%0d,%0d) d %0d last %0b",
                   want.index, want.normal_x, want.normal_y, want.normal_z, want.offset,
                   want.last);
          $display("tb:          actual   index %0d n (%0d,%0d,%0d) d %0d last %0b",
                   got.index, got.normal_x, got.normal_y, got.normal_z, got.offset,
                   got.last);
        end
      end
    endfunction
  endclass

endpackage

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives camera poses into view_frustum_plane_extract under several register
// settings and idle/stall mixes, and checks every plane word against the
// scoreboard's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import vfpe_pkg::*;
  import frustum_plane_sb_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int N_DIRECTED  = 12;
  localparam int N_PER_PHASE = 50;
  localparam int LONG_HOLD   = 300;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  pose_t                   pose_drv = '0;
  logic                    in_stall;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PLANE_W-1:0]      plane_index;
  row_t                    normal_x, normal_y, normal_z;
  logic signed [OFS_W-1:0] plane_offset;
  logic                    last_plane;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CIDX_W-1:0]       cfg_index = '0;
  logic [CDATA_W-1:0]      cfg_data = '0;

  plane_scoreboard planes;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;

  view_frustum_plane_extract uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .right_x     (pose_drv.right_x),
    .right_y     (pose_drv.right_y),
    .right_z     (pose_drv.right_z),
    .up_x        (pose_drv.up_x),
    .up_y        (pose_drv.up_y),
    .up_z        (pose_drv.up_z),
    .forward_x   (pose_drv.forward_x),
    .forward_y   (pose_drv.forward_y),
    .forward_z   (pose_drv.forward_z),
    .pos_x       (pose_drv.pos_x),
    .pos_y       (pose_drv.pos_y),
    .pos_z       (pose_drv.pos_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plane_index (plane_index),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .plane_offset(plane_offset),
    .last_plane  (last_plane),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random stalls, or a long hold-off each time hold_go toggles
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      planes.check_plane(plane_word_t'{plane_index, normal_x, normal_y, normal_z,
                                       plane_offset, last_plane});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic row_t rand_row();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3, 4, 5: return row_t'(int'($urandom_range(8192)) - 4096);
      default: return row_t'($urandom);
    endcase
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3, 4, 5: return pos_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.right_x   = rand_row(); p.right_y   = rand_row(); p.right_z   = rand_row();
    p.up_x      = rand_row(); p.up_y      = rand_row(); p.up_z      = rand_row();
    p.forward_x = rand_row(); p.forward_y = rand_row(); p.forward_z = rand_row();
    p.pos_x     = rand_pos(); p.pos_y     = rand_pos(); p.pos_z     = rand_pos();
    return p;
  endfunction

  // corner poses: identity, full-scale rows and positions, min forward
  // components, negative offsets that floor, bit patterns
  function automatic pose_t directed_pose(int k);
    case (k)
      0: return '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0};
      1: return '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096, 40960, -12288, 409600};
      2: return '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      3: return '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      4: return '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      5: return '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      6: return '{16'h7FFF, 16'h8000, 0, 0, 16'h7FFF, 16'h8000,
                  16'h8000, 0, 16'h7FFF, -1, -1, -1};
      7: return '{1, -1, 3, -2, 5, -7, 1, -1, 1, 1, -1, -4095};
      8: return '0;
      9: return '{0, 0, -4096, 0, 4096, 0, 4096, 0, 0, -123456, 7890, 555555};
      10: return '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                   16'h5555, 16'hAAAA, 16'h5555,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
      default: return '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'hAAAA, 16'h5555, 16'hAAAA,
                        32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
    endcase
  endfunction

  // valid stays high across back-to-back words; idle cycles and drain() drop it
  task automatic send_pose(pose_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pose_drv <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    planes.note_pose(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (planes.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] index, logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    planes.write_reg(index, data);
  endtask

  // unused upper data bits of the 10-bit registers carry noise
  task automatic set_regs(int hw, int hh, int fl, int fd);
    logic [CDATA_W-1:0] noise;
    noise = $urandom;
    write_reg(REG_HALF_WIDTH, {noise[CDATA_W-1:CFG_W], CFG_W'(hw)});
    noise = $urandom;
    write_reg(REG_HALF_HEIGHT, {noise[CDATA_W-1:CFG_W], CFG_W'(hh)});
    noise = $urandom;
    write_reg(REG_FOCAL_LENGTH, {noise[CDATA_W-1:CFG_W], CFG_W'(fl)});
    write_reg(REG_FAR_DISTANCE, CDATA_W'(fd));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    planes = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, corner poses, no idling
    for (int k = 0; k < N_DIRECTED; k++)
      send_pose(directed_pose(k));
    drain();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          set_regs(1023, 1023, 1023, 65535);
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        2: begin
          set_regs(0, 0, 0, 0);
          send_idle_pct = 78;
          stall_pct <= 0;
        end
        3: begin
          set_regs($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(65535));
          send_idle_pct = 0;
          stall_pct <= 78;
        end
        4: begin
          set_regs($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(65535));
          send_idle_pct = 10;
          stall_pct <= 10;
          hold_go <= !hold_go;
        end
        default: begin
          set_regs($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(65535));
          send_idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      for (int i = 0; i < N_PER_PHASE; i++) begin
        // sender waits mid-phase until the pipe is empty
        if (ph == 3 && i == N_PER_PHASE / 2)
          drain();
        send_pose(i < 4 ? directed_pose($urandom_range(N_DIRECTED - 1)) : rand_pose());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (planes.errors == 0 && planes.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: view_frustum_plane_extract.f
rtl/core/vfpe_pkg.sv
rtl/core/view_frustum_plane_extract.sv
sim/frustum_plane_sb_pkg.sv
sim/tb.sv
